[sv/jac_pkg.sv]
package jac_pkg;

   localparam int SAMPLES_PER_READ = 9;
   localparam int TRIM_EACH_END    = 2;
   localparam int SAMPLE_BITS      = 12;

   localparam int FRAC_BITS  = 16;
   localparam int LEVEL_W    = SAMPLE_BITS + FRAC_BITS;
   localparam int GAIN_W     = 17;
   localparam int FULL_SCALE = 1000;
   localparam int PCT_DIV    = 10;

   // ranks kept by the trimmed mean
   localparam int KEEP_LO  = (2 * TRIM_EACH_END >= SAMPLES_PER_READ) ?
                             SAMPLES_PER_READ / 2 : TRIM_EACH_END;
   localparam int KEEP_HI  = (2 * TRIM_EACH_END >= SAMPLES_PER_READ) ?
                             SAMPLES_PER_READ / 2 :
                             SAMPLES_PER_READ - TRIM_EACH_END - 1;
   localparam int KEEP_CNT = KEEP_HI - KEEP_LO + 1;

   localparam int IDX_W   = 4;
   localparam int ADDR_W  = 5;
   localparam int SUM_W   = SAMPLE_BITS + 4;

   // shared serial divider
   localparam int DIV_N_W = 22;
   localparam int DIV_D_W = 13;
   localparam int DIV_C_W = 5;

   // serial multiplier
   localparam int DIFF_W  = LEVEL_W + 1;
   localparam int PROD_W  = DIFF_W + GAIN_W + 1;
   localparam int MUL_C_W = 5;

   localparam int CSR_AW  = 5;

   typedef enum logic [2:0] {
      REG_SPAN_MIN  = 3'd0,
      REG_SPAN_MAX  = 3'd1,
      REG_CENTER_X  = 3'd2,
      REG_CENTER_Y  = 3'd3,
      REG_DEAD_BAND = 3'd4,
      REG_GAIN_SLOW = 3'd5,
      REG_GAIN_FAST = 3'd6,
      REG_STEP_THR  = 3'd7
   } reg_index_type;

endpackage

[sv/jac_div.sv]
module jac_div
   import jac_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_N_W-1:0] dividend,
   input  logic [DIV_D_W-1:0] divisor,
   output logic               done,
   output logic [DIV_N_W-1:0] quotient
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DIV_C_W-1:0] cnt_ff, cnt_in;
   logic [DIV_N_W-1:0] num_ff, num_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in;
   logic [DIV_D_W-1:0] den_ff, den_in;
   logic [DIV_D_W:0]   trial;
   logic               qbit;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial   = {rem_ff, num_ff[DIV_N_W-1]};
      qbit    = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_C_W'(DIV_N_W - 1);
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = qbit ? DIV_D_W'(trial - {1'b0, den_ff}) : trial[DIV_D_W-1:0];
         num_in = {num_ff[DIV_N_W-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

[sv/jac_mul.sv]
module jac_mul
   import jac_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [GAIN_W-1:0]        gain,
   input  logic signed [DIFF_W-1:0] diff,
   output logic                     done,
   output logic signed [PROD_W-1:0] product
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [MUL_C_W-1:0]       cnt_ff, cnt_in;
   logic [GAIN_W-1:0]        gain_ff, gain_in;
   logic signed [PROD_W-1:0] mcand_ff, mcand_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;

   // shift-add, one gain bit per cycle
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      gain_in  = gain_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = MUL_C_W'(GAIN_W - 1);
         gain_in  = gain;
         mcand_in = PROD_W'(diff);
         acc_in   = '0;
      end else if (busy_ff) begin
         if (gain_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in = mcand_ff <<< 1;
         gain_in  = gain_ff >> 1;
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      gain_ff  <= gain_in;
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

[sv/joystick_axis_conditioner_core.sv]
// Samples that do not complete a set of nine are stored and give no word.
// The ninth sample of an axis starts a read: store readout, a serial rank
// count for each sample, the serial divider for the mean, the filter multiply
// once the axis is primed, then the divider for the position and its percent.
// One read is worked at a time; the result word waits in an output register.
// Synchronous reset loads register defaults, clears fill counts and filters.
module joystick_axis_conditioner_core
   import jac_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,   // [11:0] raw_sample
   input  logic              req_tuser,   // [0] axis_select
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // [11:0] mean_raw, [22:12] position_tenths,
                                          // [30:23] position_percent
   output logic              rsp_tuser,   // [0] axis_id
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_CAPT, ST_RANK, ST_ACC, ST_MEAN, ST_MEAN_W,
      ST_FILT, ST_MUL_W, ST_SCALE, ST_SDIV_W, ST_PCT_W, ST_OUT
   } state_type;

   // configuration
   logic [11:0]       span_min_ff, span_max_ff, center_x_ff, center_y_ff;
   logic [11:0]       dead_band_ff, step_thr_ff;
   logic [GAIN_W-1:0] gain_slow_ff, gain_fast_ff;
   logic              csr_wr;
   reg_index_type     csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = reg_index_type'(csr_paddr[CSR_AW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         span_min_ff  <= 12'd0;
         span_max_ff  <= 12'd4095;
         center_x_ff  <= 12'd2048;
         center_y_ff  <= 12'd2048;
         dead_band_ff <= 12'd100;
         gain_slow_ff <= GAIN_W'(1966);
         gain_fast_ff <= GAIN_W'(16384);
         step_thr_ff  <= 12'd250;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_SPAN_MIN:  span_min_ff  <= csr_pwdata[11:0];
            REG_SPAN_MAX:  span_max_ff  <= csr_pwdata[11:0];
            REG_CENTER_X:  center_x_ff  <= csr_pwdata[11:0];
            REG_CENTER_Y:  center_y_ff  <= csr_pwdata[11:0];
            REG_DEAD_BAND: dead_band_ff <= csr_pwdata[11:0];
            REG_GAIN_SLOW: gain_slow_ff <= csr_pwdata[GAIN_W-1:0];
            REG_GAIN_FAST: gain_fast_ff <= csr_pwdata[GAIN_W-1:0];
            REG_STEP_THR:  step_thr_ff  <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_SPAN_MIN:  csr_prdata = {20'd0, span_min_ff};
         REG_SPAN_MAX:  csr_prdata = {20'd0, span_max_ff};
         REG_CENTER_X:  csr_prdata = {20'd0, center_x_ff};
         REG_CENTER_Y:  csr_prdata = {20'd0, center_y_ff};
         REG_DEAD_BAND: csr_prdata = {20'd0, dead_band_ff};
         REG_GAIN_SLOW: csr_prdata = 32'(gain_slow_ff);
         REG_GAIN_FAST: csr_prdata = 32'(gain_fast_ff);
         REG_STEP_THR:  csr_prdata = {20'd0, step_thr_ff};
         default:       csr_prdata = '0;
      endcase
   end

   // sample store, one set of nine per axis
   logic [SAMPLE_BITS-1:0] mem [0:2*SAMPLES_PER_READ-1];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [ADDR_W-1:0]      wr_addr, rd_addr, base_in, base_ff;

   state_type              state_ff;
   logic                   ax_ff;
   logic [IDX_W-1:0]       fill_ff [2];
   logic [IDX_W-1:0]       ld_cnt_ff, i_ff, j_ff, k_ff, rank_ff;
   logic [SAMPLE_BITS-1:0] ring_ff [SAMPLES_PER_READ];
   logic [SAMPLE_BITS-1:0] key_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic [SAMPLE_BITS-1:0] mean_ff;
   logic [LEVEL_W-1:0]     level_ff [2];
   logic                   primed_ff [2];
   logic                   neg_ff;
   logic signed [10:0]     tenths_ff;
   logic signed [7:0]      pct_ff;
   logic                   rsp_valid_ff;
   logic [31:0]            rsp_data_ff;
   logic                   rsp_user_ff;

   logic                   req_acc, completes, ring_less;
   logic [IDX_W-1:0]       rank_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign completes  = (fill_ff[req_tuser] == IDX_W'(SAMPLES_PER_READ - 1));
   assign base_in    = req_tuser ? ADDR_W'(SAMPLES_PER_READ) : '0;
   assign wr_addr    = base_in + ADDR_W'(fill_ff[req_tuser]);
   assign rd_addr    = base_ff + ((ld_cnt_ff < IDX_W'(SAMPLES_PER_READ)) ?
                                  ADDR_W'(ld_cnt_ff) : '0);

   always_ff @(posedge clock) begin
      if (req_acc) begin
         mem[wr_addr] <= req_tdata[SAMPLE_BITS-1:0];
      end
      rd_data_ff <= mem[rd_addr];
   end

   // rank of the key among the set; ties broken by position
   assign ring_less = (ring_ff[0] < key_ff) || ((ring_ff[0] == key_ff) && (j_ff < i_ff));
   assign rank_in   = rank_ff + IDX_W'(ring_less);

   // shared units
   logic               div_start_ff, div_done;
   logic [DIV_N_W-1:0] div_num_ff, div_q;
   logic [DIV_D_W-1:0] div_den_ff;
   logic               mul_start_ff, mul_done;
   logic [GAIN_W-1:0]  mul_gain_ff;
   logic signed [DIFF_W-1:0] mul_diff_ff;
   logic signed [PROD_W-1:0] mul_prod;

   jac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_num_ff),
      .divisor  (div_den_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   jac_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .gain    (mul_gain_ff),
      .diff    (mul_diff_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   // filter step
   logic [LEVEL_W-1:0]       target, cur_level, delta;
   logic [GAIN_W-1:0]        gain_sel, gain_clip;
   logic signed [PROD_W-1:0] level_sum;

   assign target    = {mean_ff, FRAC_BITS'(0)};
   assign cur_level = level_ff[ax_ff];
   assign delta     = (target > cur_level) ? target - cur_level : cur_level - target;
   assign gain_sel  = (delta > {step_thr_ff, FRAC_BITS'(0)}) ? gain_fast_ff : gain_slow_ff;
   assign gain_clip = (gain_sel > GAIN_W'(1 << FRAC_BITS)) ? GAIN_W'(1 << FRAC_BITS)
                                                            : gain_sel;
   assign level_sum = $signed({{(PROD_W-LEVEL_W){1'b0}}, cur_level}) +
                      (mul_prod >>> FRAC_BITS);

   // dead zone and span
   logic signed [13:0] pos_s, cen_s, dz_s, d_s, span_lo, span_hi, num_lo, num_hi;
   logic               in_dead, below;
   logic [11:0]        num_sel;
   logic [DIV_N_W-1:0] num_x1000;
   logic [10:0]        mag_q;

   assign pos_s   = {2'b00, cur_level[LEVEL_W-1:FRAC_BITS]};
   assign cen_s   = {2'b00, (ax_ff ? center_y_ff : center_x_ff)};
   assign dz_s    = {2'b00, dead_band_ff};
   assign d_s     = pos_s - cen_s;
   assign in_dead = (d_s <= dz_s) && (-d_s <= dz_s);
   assign below   = (pos_s < cen_s);
   assign span_lo = cen_s - dz_s - {2'b00, span_min_ff};
   assign span_hi = {2'b00, span_max_ff} - cen_s - dz_s;
   assign num_lo  = cen_s - dz_s - pos_s;
   assign num_hi  = pos_s - cen_s - dz_s;
   assign num_sel = below ? num_lo[11:0] : num_hi[11:0];
   // times 1000 as 1024 - 16 - 8
   assign num_x1000 = (DIV_N_W'(num_sel) << 10) - (DIV_N_W'(num_sel) << 4) -
                      (DIV_N_W'(num_sel) << 3);
   assign mag_q     = (div_q > DIV_N_W'(FULL_SCALE)) ? 11'(FULL_SCALE) : div_q[10:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff[0]   <= '0;
         fill_ff[1]   <= '0;
         level_ff[0]  <= '0;
         level_ff[1]  <= '0;
         primed_ff[0] <= 1'b0;
         primed_ff[1] <= 1'b0;
         div_start_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // one-cycle start pulses for the shared units
         div_start_ff <= (state_ff == ST_MEAN) || (state_ff == ST_SCALE) ||
                         ((state_ff == ST_SDIV_W) && div_done);
         mul_start_ff <= (state_ff == ST_FILT) && primed_ff[ax_ff];
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  if (completes) begin
                     fill_ff[req_tuser] <= '0;
                     ax_ff     <= req_tuser;
                     base_ff   <= base_in;
                     ld_cnt_ff <= '0;
                     state_ff  <= ST_LOAD;
                  end else begin
                     fill_ff[req_tuser] <= fill_ff[req_tuser] + 1'b1;
                  end
               end
            end
            ST_LOAD: begin
               if (ld_cnt_ff != '0) begin
                  for (int n = 0; n < SAMPLES_PER_READ - 1; n++) begin
                     ring_ff[n] <= ring_ff[n+1];
                  end
                  ring_ff[SAMPLES_PER_READ-1] <= rd_data_ff;
               end
               ld_cnt_ff <= ld_cnt_ff + 1'b1;
               if (ld_cnt_ff == IDX_W'(SAMPLES_PER_READ)) begin
                  i_ff     <= '0;
                  sum_ff   <= '0;
                  state_ff <= ST_CAPT;
               end
            end
            ST_CAPT: begin
               key_ff   <= ring_ff[0];
               j_ff     <= i_ff;
               k_ff     <= '0;
               rank_ff  <= '0;
               state_ff <= ST_RANK;
            end
            ST_RANK: begin
               rank_ff <= rank_in;
               for (int n = 0; n < SAMPLES_PER_READ - 1; n++) begin
                  ring_ff[n] <= ring_ff[n+1];
               end
               ring_ff[SAMPLES_PER_READ-1] <= ring_ff[0];
               j_ff <= (j_ff == IDX_W'(SAMPLES_PER_READ - 1)) ? '0 : j_ff + 1'b1;
               k_ff <= k_ff + 1'b1;
               if (k_ff == IDX_W'(SAMPLES_PER_READ - 1)) begin
                  state_ff <= ST_ACC;
               end
            end
            ST_ACC: begin
               if (rank_ff >= IDX_W'(KEEP_LO) && rank_ff <= IDX_W'(KEEP_HI)) begin
                  sum_ff <= sum_ff + SUM_W'(key_ff);
               end
               for (int n = 0; n < SAMPLES_PER_READ - 1; n++) begin
                  ring_ff[n] <= ring_ff[n+1];
               end
               ring_ff[SAMPLES_PER_READ-1] <= ring_ff[0];
               i_ff <= i_ff + 1'b1;
               state_ff <= (i_ff == IDX_W'(SAMPLES_PER_READ - 1)) ? ST_MEAN : ST_CAPT;
            end
            ST_MEAN: begin
               div_num_ff   <= DIV_N_W'(sum_ff);
               div_den_ff   <= DIV_D_W'(KEEP_CNT);
               state_ff     <= ST_MEAN_W;
            end
            ST_MEAN_W: begin
               if (div_done) begin
                  mean_ff  <= div_q[SAMPLE_BITS-1:0];
                  state_ff <= ST_FILT;
               end
            end
            ST_FILT: begin
               if (!primed_ff[ax_ff]) begin
                  level_ff[ax_ff]  <= target;
                  primed_ff[ax_ff] <= 1'b1;
                  state_ff         <= ST_SCALE;
               end else begin
                  mul_gain_ff  <= gain_clip;
                  mul_diff_ff  <= $signed({1'b0, target}) - $signed({1'b0, cur_level});
                  state_ff     <= ST_MUL_W;
               end
            end
            ST_MUL_W: begin
               if (mul_done) begin
                  level_ff[ax_ff] <= level_sum[LEVEL_W-1:0];
                  state_ff        <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               neg_ff <= below;
               if (in_dead) begin
                  tenths_ff    <= '0;
                  div_num_ff   <= '0;
                  div_den_ff   <= DIV_D_W'(PCT_DIV);
                  state_ff     <= ST_PCT_W;
               end else if ((below && span_lo <= 0) || (!below && span_hi <= 0)) begin
                  tenths_ff    <= below ? -11'sd1000 : 11'sd1000;
                  div_num_ff   <= DIV_N_W'(FULL_SCALE);
                  div_den_ff   <= DIV_D_W'(PCT_DIV);
                  state_ff     <= ST_PCT_W;
               end else begin
                  div_num_ff   <= num_x1000;
                  div_den_ff   <= below ? span_lo[DIV_D_W-1:0] : span_hi[DIV_D_W-1:0];
                  state_ff     <= ST_SDIV_W;
               end
            end
            ST_SDIV_W: begin
               if (div_done) begin
                  tenths_ff    <= neg_ff ? -$signed(mag_q) : $signed(mag_q);
                  div_num_ff   <= DIV_N_W'(mag_q);
                  div_den_ff   <= DIV_D_W'(PCT_DIV);
                  state_ff     <= ST_PCT_W;
               end
            end
            ST_PCT_W: begin
               if (div_done) begin
                  pct_ff   <= neg_ff ? -$signed(div_q[7:0]) : $signed(div_q[7:0]);
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_user_ff  <= ax_ff;
                  rsp_data_ff  <= {1'b0, pct_ff, tenths_ff, mean_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef NO_ASSERTIONS
   a_tenths_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[22:12]) >= -11'sd1000 &&
                      $signed(rsp_tdata[22:12]) <= 11'sd1000))
      else $error("tenths out of range");
   a_pct_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[30] == 1'b0 || rsp_tdata[22] == 1'b1))
      else $error("percent sign disagrees with tenths");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff[0] < IDX_W'(SAMPLES_PER_READ) && fill_ff[1] < IDX_W'(SAMPLES_PER_READ))
      else $error("fill count overrun");
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_MEAN_W || state_ff == ST_SDIV_W ||
                    state_ff == ST_PCT_W))
      else $error("divider finished with no waiting state");
`endif

endmodule
